FILE: rtl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

  localparam int unsigned TpmW     = 10;
  localparam int unsigned LimitW   = 8;
  localparam int unsigned DelayW   = TpmW + 2;
  localparam int unsigned PollW    = LimitW + 1;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [TpmW-1:0]   TpmReset   = TpmW'(100);
  localparam logic [LimitW-1:0] LimitReset = LimitW'(250);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TPM   = 2'd0,
    CFG_LIMIT = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_WACK  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic       cmd_valid;
    cmd_e       cmd;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_sampled;
  } cmd_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_failed;
  } res_word_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_word_t;

  typedef struct packed {
    logic [TpmW-1:0]   tpm;
    logic [LimitW-1:0] limit;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/i2cm_if.sv
`default_nettype none

interface i2cm_cmd_if;
  import i2cm_pkg::*;
  logic      valid;
  logic      ready;
  cmd_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface i2cm_res_if;
  import i2cm_pkg::*;
  logic      valid;
  logic      ready;
  res_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface i2cm_cfg_if;
  import i2cm_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

FILE: rtl/i2c_master_bit_engine_core.sv
`default_nettype none

// I2C master bit engine. Every command word is one bus tick and yields exactly one result word
// carrying the SCL level, SDA drive level, busy, done, last read byte and acknowledge failure
// after that tick. A new word is taken every cycle as long as the result
// register is empty or being taken in the same cycle; the tick's next state is worked out in
// one pass and stored alongside the result. Commands are honoured only while idle. Line phases
// last whole microseconds of ticks_per_microsecond ticks. The configuration port is always
// ready; write it only while no command is in progress.
module i2c_master_bit_engine_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  i2cm_cmd_if.sink   cmd_i,
  i2cm_res_if.source res_o,
  i2cm_cfg_if.sink   cfg_i
);
  import i2cm_pkg::*;

  logic      res_valid_q;
  res_word_t res_word_q;
  res_word_t res_word;
  cfg_t      cfg;
  logic      step;

  assign cmd_i.ready = ~res_valid_q | res_o.ready;
  assign step        = cmd_i.valid & cmd_i.ready;
  assign cfg_i.ready = 1'b1;

  i2cm_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cfg_i.valid),
    .wr_word_i (cfg_i.word),
    .cfg_o     (cfg)
  );

  i2cm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cmd_i  (cmd_i.word),
    .cfg_i  (cfg),
    .res_o  (res_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_word_q <= res_word;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.word  = res_word_q;

endmodule

`default_nettype wire

FILE: rtl/i2cm_cfg.sv
`default_nettype none

module i2cm_cfg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_i,
  input  wire i2cm_pkg::cfg_word_t wr_word_i,
  output      i2cm_pkg::cfg_t      cfg_o
);
  import i2cm_pkg::*;

  logic [TpmW-1:0]   tpm_q;
  logic [LimitW-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q   <= TpmReset;
      limit_q <= LimitReset;
    end else if (wr_i) begin
      unique case (wr_word_i.index)
        CFG_TPM:   tpm_q   <= wr_word_i.data[TpmW-1:0];
        CFG_LIMIT: limit_q <= wr_word_i.data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.tpm   = tpm_q;
  assign cfg_o.limit = limit_q;

endmodule

`default_nettype wire

FILE: rtl/i2cm_seq.sv
`default_nettype none

module i2cm_seq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire i2cm_pkg::cmd_word_t  cmd_i,
  input  wire i2cm_pkg::cfg_t       cfg_i,
  output      i2cm_pkg::res_word_t  res_o
);
  import i2cm_pkg::*;

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_ST1  = 4'd1;
  localparam logic [3:0] PH_ST2  = 4'd2;
  localparam logic [3:0] PH_SP1  = 4'd3;
  localparam logic [3:0] PH_SP2  = 4'd4;
  localparam logic [3:0] PH_WA1  = 4'd5;
  localparam logic [3:0] PH_WA2  = 4'd6;
  localparam logic [3:0] PH_POLL = 4'd7;
  localparam logic [3:0] PH_WB1  = 4'd8;
  localparam logic [3:0] PH_WB2  = 4'd9;
  localparam logic [3:0] PH_WB3  = 4'd10;
  localparam logic [3:0] PH_RB1  = 4'd11;
  localparam logic [3:0] PH_RB2  = 4'd12;
  localparam logic [3:0] PH_RA1  = 4'd13;
  localparam logic [3:0] PH_RA2  = 4'd14;

  logic [3:0]        phase_q, phase_d;
  logic [DelayW-1:0] delay_q, delay_d;
  logic [2:0]        bit_q, bit_d;
  logic [7:0]        shift_q, shift_d;
  logic [PollW-1:0]  poll_q, poll_d;
  logic              ack_flag_q, ack_flag_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              ack_choice_q, ack_choice_d;
  logic [7:0]        read_q, read_d;

  logic              done;
  logic              ent;
  logic [3:0]        ent_ph;
  logic [TpmW-1:0]   unit;
  logic [DelayW-1:0] load1, load2, load4;
  logic [PollW-1:0]  poll_next;
  logic              poll_now;

  // one microsecond is never shorter than one tick
  assign unit  = (cfg_i.tpm == '0) ? TpmW'(1) : cfg_i.tpm;
  assign load1 = {2'b00, unit} - DelayW'(1);
  assign load2 = {1'b0, unit, 1'b0} - DelayW'(1);
  assign load4 = {unit, 2'b00} - DelayW'(1);

  assign poll_now  = (phase_q == PH_POLL) || ((phase_q == PH_WA2) && (delay_q == '0));
  assign poll_next = ((phase_q == PH_POLL) ? poll_q : '0) + PollW'(1);

  always_comb begin
    phase_d      = phase_q;
    delay_d      = delay_q;
    bit_d        = bit_q;
    shift_d      = shift_q;
    poll_d       = poll_q;
    ack_flag_d   = ack_flag_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    ack_choice_d = ack_choice_q;
    read_d       = read_q;
    done         = 1'b0;
    ent          = 1'b0;
    ent_ph       = PH_IDLE;

    priority if (phase_q == PH_IDLE) begin
      if (cmd_i.cmd_valid) begin
        unique case (cmd_i.cmd)
          CMD_START: begin
            ent    = 1'b1;
            ent_ph = PH_ST1;
          end
          CMD_STOP: begin
            ent    = 1'b1;
            ent_ph = PH_SP1;
          end
          CMD_WRITE: begin
            shift_d = cmd_i.write_byte;
            bit_d   = '0;
            ent     = 1'b1;
            ent_ph  = PH_WB1;
          end
          CMD_WACK: begin
            ack_flag_d = 1'b0;
            poll_d     = '0;
            ent        = 1'b1;
            ent_ph     = PH_WA1;
          end
          CMD_READ: begin
            ack_choice_d = cmd_i.send_ack;
            shift_d      = '0;
            bit_d        = '0;
            sda_d        = 1'b1;
            ent          = 1'b1;
            ent_ph       = PH_RB1;
          end
          default: ;
        endcase
      end
    end else if (poll_now) begin
      phase_d = PH_POLL;
      if (!cmd_i.sda_sampled) begin
        scl_d      = 1'b0;
        ack_flag_d = 1'b0;
        phase_d    = PH_IDLE;
        done       = 1'b1;
      end else begin
        poll_d = poll_next;
        if (poll_next > {1'b0, cfg_i.limit}) begin
          ack_flag_d = 1'b1;
          ent        = 1'b1;
          ent_ph     = PH_SP1;
        end
      end
    end else if (delay_q != '0) begin
      delay_d = delay_q - DelayW'(1);
    end else begin
      unique case (phase_q)
        PH_ST1: begin
          ent    = 1'b1;
          ent_ph = PH_ST2;
        end
        PH_ST2: begin
          scl_d   = 1'b0;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
        PH_SP1: begin
          ent    = 1'b1;
          ent_ph = PH_SP2;
        end
        PH_SP2: begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
        PH_WA1: begin
          ent    = 1'b1;
          ent_ph = PH_WA2;
        end
        PH_WB1: begin
          ent    = 1'b1;
          ent_ph = PH_WB2;
        end
        PH_WB2: begin
          ent    = 1'b1;
          ent_ph = PH_WB3;
        end
        PH_WB3: begin
          if (bit_q != 3'd7) begin
            bit_d   = bit_q + 3'd1;
            shift_d = {shift_q[6:0], 1'b0};
            ent     = 1'b1;
            ent_ph  = PH_WB1;
          end else begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        end
        PH_RB1: begin
          ent    = 1'b1;
          ent_ph = PH_RB2;
        end
        PH_RB2: begin
          if (bit_q != 3'd7) begin
            bit_d  = bit_q + 3'd1;
            ent    = 1'b1;
            ent_ph = PH_RB1;
          end else begin
            read_d = shift_q;
            ent    = 1'b1;
            ent_ph = PH_RA1;
          end
        end
        PH_RA1: begin
          ent    = 1'b1;
          ent_ph = PH_RA2;
        end
        PH_RA2: begin
          scl_d   = 1'b0;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
        default: phase_d = PH_IDLE;
      endcase
    end

    // line levels and hold time of the phase being entered
    if (ent) begin
      phase_d = ent_ph;
      unique case (ent_ph)
        PH_ST1: begin
          sda_d   = 1'b1;
          scl_d   = 1'b1;
          delay_d = load4;
        end
        PH_ST2: begin
          sda_d   = 1'b0;
          delay_d = load4;
        end
        PH_SP1: begin
          scl_d   = 1'b0;
          sda_d   = 1'b0;
          delay_d = load4;
        end
        PH_SP2: begin
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          delay_d = load4;
        end
        PH_WA1: begin
          sda_d   = 1'b1;
          delay_d = load1;
        end
        PH_WA2: begin
          scl_d   = 1'b1;
          delay_d = load1;
        end
        PH_WB1: begin
          scl_d   = 1'b0;
          sda_d   = shift_d[7];
          delay_d = load2;
        end
        PH_WB2: begin
          scl_d   = 1'b1;
          delay_d = load2;
        end
        PH_WB3: begin
          scl_d   = 1'b0;
          delay_d = load2;
        end
        PH_RB1: begin
          scl_d   = 1'b0;
          delay_d = load2;
        end
        PH_RB2: begin
          scl_d   = 1'b1;
          shift_d = {shift_d[6:0], cmd_i.sda_sampled};
          delay_d = load1;
        end
        PH_RA1: begin
          scl_d   = 1'b0;
          sda_d   = ~ack_choice_q;
          delay_d = load2;
        end
        PH_RA2: begin
          scl_d   = 1'b1;
          delay_d = load2;
        end
        default: begin
          phase_d = PH_IDLE;
          delay_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      delay_q      <= '0;
      bit_q        <= '0;
      shift_q      <= '0;
      poll_q       <= '0;
      ack_flag_q   <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      ack_choice_q <= 1'b0;
      read_q       <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      delay_q      <= delay_d;
      bit_q        <= bit_d;
      shift_q      <= shift_d;
      poll_q       <= poll_d;
      ack_flag_q   <= ack_flag_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      ack_choice_q <= ack_choice_d;
      read_q       <= read_d;
    end
  end

  assign res_o.scl_level  = scl_d;
  assign res_o.sda_level  = sda_d;
  assign res_o.busy_res   = (phase_d != PH_IDLE);
  assign res_o.done_res   = done;
  assign res_o.read_data  = read_d;
  assign res_o.ack_failed = ack_flag_d;

  a_idle_no_delay : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (delay_q == '0))
    else $error("delay count left running while idle");

  a_poll_no_delay : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_POLL) |-> (delay_q == '0))
    else $error("delay count running during acknowledge poll");

  a_done_goes_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.done_res) |=> (phase_q == PH_IDLE))
    else $error("command completed but sequencer not idle");

endmodule

`default_nettype wire
